// ===== hdl/usbch_pkg.sv =====
// Package: shared types, stage/split codes and pipeline sizing for the channel update.
`default_nettype none
package usbch_pkg;

    localparam int XW      = 19;                 // byte count width
    localparam int MW      = 11;                 // packet size width
    localparam int PW      = 10;                 // packet count width
    localparam int EW      = 11;                 // error flag width
    localparam int IW      = 14;                 // interrupt bit width
    localparam int RW      = MW + 1;             // divider partial remainder width
    localparam int DIV_SPS = 4;                  // quotient bits per divider stage
    localparam int DIV_STG = (XW + DIV_SPS - 1) / DIV_SPS;

    typedef enum logic [3:0] {
        ST_SETUP  = 4'd0,
        ST_DATA   = 4'd1,
        ST_ACK    = 4'd2,
        ST_DONE   = 4'd3,
        ST_PDATA  = 4'd4,
        ST_PACK   = 4'd5,
        ST_PDONE  = 4'd6,
        ST_CANCEL = 4'd7,
        ST_CDONE  = 4'd8
    } stage_code_t;

    typedef enum logic [1:0] {
        SP_NONE  = 2'd0,
        SP_START = 2'd1,
        SP_COMPL = 2'd2
    } split_code_t;

    localparam int IRQ_DONE = 0;
    localparam int IRQ_HALT = 1;
    localparam int IRQ_AHB  = 2;
    localparam int IRQ_STALL = 3;
    localparam int IRQ_NAK  = 4;
    localparam int IRQ_NYET = 6;

    typedef struct packed {
        logic [IW-1:0] interrupt_bits;
        logic [XW-1:0] remaining_bytes;
        logic [3:0]    stage;
        logic [1:0]    split_state;
        logic [PW-1:0] packets_left;
        logic [MW-1:0] max_packet;
        logic [XW-1:0] request_bytes;
        logic [31:0]   offset_bytes;
        logic          data_toggle;
        logic          poll_toggle;
        logic [EW-1:0] errors_in;
    } in_t;

    typedef struct packed {
        logic [3:0]    next_stage;
        logic [1:0]    next_split_state;
        logic [PW-1:0] next_packets_left;
        logic [MW-1:0] next_max_packet;
        logic [31:0]   next_offset_bytes;
        logic [31:0]   final_bytes;
        logic          final_valid;
        logic          next_data_toggle;
        logic          next_poll_toggle;
        logic [EW-1:0] errors_out;
        logic          advanced;
        logic          unknown_stage;
    } out_t;

    // Record carried from the decode stage to the finish stage.
    typedef struct packed {
        logic          halt_or_done;
        logic          tc;
        logic          nak;
        logic [3:0]    stage;
        logic [1:0]    phase;
        logic [PW-1:0] pkts;
        logic [MW-1:0] mps;
        logic          req_nz;
        logic [31:0]   offset;
        logic [XW-1:0] xfer;
        logic          short_pkt;
        logic          count_pkts;
        logic          split_done;
        logic          dtog;
        logic          ptog;
        logic [EW-1:0] errs;
    } mid_t;

endpackage
`default_nettype wire

// ===== hdl/usbch_div.sv =====
// Pipelined restoring divider: byte count over packet size, several quotient bits per stage.
`default_nettype none
module usbch_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic [usbch_pkg::XW-1:0] dividend,
    input  wire logic [usbch_pkg::MW-1:0] divisor,
    output logic                          out_valid,
    output logic [usbch_pkg::XW-1:0]      quotient,
    output logic [usbch_pkg::MW-1:0]      remainder
);
    import usbch_pkg::*;

    logic [XW-1:0] dq_reg  [DIV_STG];
    logic [RW-1:0] rem_reg [DIV_STG];
    logic [MW-1:0] dvs_reg [DIV_STG];
    logic          vld_reg [DIV_STG];

    for (genvar s = 0; s < DIV_STG; s++) begin : g_stg
        logic [XW-1:0] dq_in;
        logic [RW-1:0] rem_in;
        logic [MW-1:0] dvs_in;
        logic          vld_in;
        logic [XW-1:0] dq_next;
        logic [RW-1:0] rem_next;

        if (s == 0) begin : g_first
            assign dq_in  = dividend;
            assign rem_in = '0;
            assign dvs_in = divisor;
            assign vld_in = in_valid;
        end else begin : g_rest
            assign dq_in  = dq_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign dvs_in = dvs_reg[s-1];
            assign vld_in = vld_reg[s-1];
        end

        always_comb
        begin
            logic [RW:0] t;
            t        = '0;
            dq_next  = dq_in;
            rem_next = rem_in;
            for (int k = 0; k < DIV_SPS; k++)
            begin
                if (s * DIV_SPS + k < XW)
                begin
                    t = {rem_next, dq_next[XW-1]};
                    if (t >= {2'b00, dvs_in})
                    begin
                        t        = t - {2'b00, dvs_in};
                        dq_next  = {dq_next[XW-2:0], 1'b1};
                    end
                    else
                    begin
                        dq_next  = {dq_next[XW-2:0], 1'b0};
                    end
                    rem_next = t[RW-1:0];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            dq_reg[s]  <= dq_next;
            rem_reg[s] <= rem_next;
            dvs_reg[s] <= dvs_in;
        end
    end

    assign out_valid = vld_reg[DIV_STG-1];
    assign quotient  = dq_reg[DIV_STG-1];
    assign remainder = rem_reg[DIV_STG-1][MW-1:0];

endmodule
`default_nettype wire

// ===== hdl/usb_channel_halt_update.sv =====
// Top level: pipelined USB host-channel halt/complete event update.
`default_nettype none
// How to use:
//   Drive one channel event on cmd and raise start. busy is always low, so an
//   event is taken on every cycle that start is high; events may follow each
//   other back to back with no gaps.
//   Each transfer produces exactly one result. done pulses for one cycle with
//   the updated channel record on result; the receiver must take it then,
//   since the block never holds a result.
// Pipeline and throughput:
//   One event per clock. An event passes one decode stage, DIV_STG stages
//   of the packet-count divider (4 quotient bits each, over the default
//   19-bit byte count), and one finish stage that forms the new record.
//   The divider depth sets the latency.
// Reset:
//   rst_n clears all valid bits at once; events in flight are dropped and
//   no done pulse follows. The block holds no channel state between events.
module usb_channel_halt_update (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire usbch_pkg::in_t cmd,
    output logic                done,
    output usbch_pkg::out_t     result
);
    import usbch_pkg::*;

    // ---------------- decode stage ----------------
    logic          irq_tc, irq_nak, irq_nyet;
    logic [EW-1:0] new_errs;
    logic [XW-1:0] xfer0, want, xfer_d;
    logic [1:0]    phase_d;
    logic          split_done_d, short_d, count_d;
    mid_t          mid_next;
    mid_t          mid_reg;
    logic          mid_vld_reg;

    assign busy     = 1'b0;
    assign irq_tc   = cmd.interrupt_bits[IRQ_DONE];
    assign irq_nak  = cmd.interrupt_bits[IRQ_NAK];
    assign irq_nyet = cmd.interrupt_bits[IRQ_NYET];

    // Map interrupt bits onto the sticky error flags.
    assign new_errs = {cmd.interrupt_bits[13:7], irq_nyet, irq_nak,
                       cmd.interrupt_bits[IRQ_STALL], cmd.interrupt_bits[IRQ_AHB]};

    assign xfer0 = (cmd.remaining_bytes <= cmd.request_bytes) ?
                   cmd.request_bytes - cmd.remaining_bytes : '0;
    assign want  = ({8'd0, cmd.max_packet} < cmd.request_bytes) ?
                   {8'd0, cmd.max_packet} : cmd.request_bytes;

    // Advance the split phase; a finished complete-split returns to start-split.
    always_comb
    begin
        phase_d      = cmd.split_state;
        split_done_d = 1'b0;
        if (cmd.split_state == SP_START)
        begin
            if (!((irq_nak && cmd.stage != ST_PDATA) || irq_nyet))
            begin
                phase_d = SP_COMPL;
            end
        end
        else if (cmd.split_state == SP_COMPL)
        begin
            if (!irq_nyet && !(irq_nak && cmd.stage != ST_PDATA) && (irq_nak || irq_tc))
            begin
                phase_d      = SP_START;
                split_done_d = 1'b1;
            end
        end
    end

    assign short_d = (xfer0 != '0) && (xfer0 < want);

    // A finished split counts as one full packet; with no request, as max_packet.
    always_comb
    begin
        xfer_d = xfer0;
        if (split_done_d && !short_d)
        begin
            xfer_d = (want == '0) ? {8'd0, cmd.max_packet} : want;
        end
    end

    assign count_d = (xfer_d != '0) || split_done_d ||
                     (phase_d == SP_NONE && cmd.request_bytes == '0);

    always_comb
    begin
        mid_next.halt_or_done = irq_tc || cmd.interrupt_bits[IRQ_HALT];
        mid_next.tc           = irq_tc;
        mid_next.nak          = irq_nak;
        mid_next.stage        = cmd.stage;
        mid_next.phase        = phase_d;
        mid_next.pkts         = cmd.packets_left;
        mid_next.mps          = cmd.max_packet;
        mid_next.req_nz       = cmd.request_bytes != '0;
        mid_next.offset       = cmd.offset_bytes;
        mid_next.xfer         = xfer_d;
        mid_next.short_pkt    = short_d;
        mid_next.count_pkts   = count_d;
        mid_next.split_done   = split_done_d;
        mid_next.dtog         = cmd.data_toggle;
        mid_next.ptog         = cmd.poll_toggle;
        mid_next.errs         = cmd.errors_in | new_errs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_vld_reg <= 1'b0;
        end
        else
        begin
            mid_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg <= mid_next;
    end

    // ---------------- divider stages ----------------
    logic          div_vld;
    logic [XW-1:0] div_q;
    logic [MW-1:0] div_r;
    mid_t          side_reg [DIV_STG];

    usbch_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_vld_reg),
        .dividend  (mid_reg.xfer),
        .divisor   (mid_reg.mps),
        .out_valid (div_vld),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Carry the record alongside the divider, one slot per divider stage.
    always_ff @(posedge clk)
    begin
        side_reg[0] <= mid_reg;
        for (int i = 1; i < DIV_STG; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // ---------------- finish stage ----------------
    mid_t          sd;
    logic [XW-1:0] dec;
    logic [PW-1:0] pkts_n;
    logic          adv_c;
    out_t          out_next;
    out_t          out_reg;
    logic          done_reg;

    assign sd  = side_reg[DIV_STG-1];
    // A partial packet or a zero packet size counts as one packet.
    assign dec = (sd.mps == '0 || div_r != '0) ? XW'(1) : div_q;

    always_comb
    begin
        pkts_n = sd.pkts;
        if (sd.short_pkt)
        begin
            pkts_n = '0;
        end
        else if (sd.count_pkts)
        begin
            pkts_n = (dec >= {9'd0, sd.pkts}) ? '0 : sd.pkts - dec[PW-1:0];
        end
    end

    assign adv_c = sd.halt_or_done &&
                   ((sd.stage == ST_SETUP && sd.tc) || (sd.stage == ST_ACK && sd.tc) ||
                    (sd.stage == ST_PDATA && (sd.tc || sd.nak)) ||
                    sd.stage == ST_CANCEL || pkts_n == '0);

    always_comb
    begin
        out_next.next_stage        = sd.stage;
        out_next.next_split_state  = sd.phase;
        out_next.next_packets_left = pkts_n;
        out_next.next_max_packet   = sd.mps;
        out_next.next_offset_bytes = sd.offset;
        out_next.final_bytes       = '0;
        out_next.final_valid       = 1'b0;
        out_next.next_data_toggle  = sd.dtog;
        out_next.next_poll_toggle  = sd.ptog;
        out_next.errors_out        = sd.errs;
        out_next.advanced          = adv_c;
        out_next.unknown_stage     = 1'b0;

        // Restart grows the offset; a finished stage clears it.
        if (sd.halt_or_done)
        begin
            if (adv_c)
            begin
                out_next.next_offset_bytes = '0;
                if (sd.stage == ST_DATA || sd.stage == ST_ACK || sd.stage == ST_PDATA)
                begin
                    out_next.final_bytes = sd.offset + {13'd0, sd.xfer};
                    out_next.final_valid = 1'b1;
                end
            end
            else
            begin
                out_next.next_offset_bytes = sd.offset + {13'd0, sd.xfer};
            end
        end

        if (sd.stage == ST_DATA && !adv_c &&
            ((pkts_n != '0 && sd.phase == SP_NONE) || (sd.req_nz && sd.split_done)))
        begin
            out_next.next_data_toggle = !sd.dtog;
        end

        if (sd.stage == ST_PDATA && sd.tc)
        begin
            out_next.next_poll_toggle = !sd.ptog;
        end

        if (adv_c)
        begin
            unique case (sd.stage)
                ST_SETUP:
                begin
                    out_next.next_packets_left = '0;
                    out_next.next_max_packet   = '0;
                    out_next.next_stage        = ST_DATA;
                end
                ST_DATA:
                begin
                    out_next.next_packets_left = '0;
                    out_next.next_max_packet   = '0;
                    out_next.next_stage        = ST_ACK;
                end
                ST_ACK:    out_next.next_stage = ST_DONE;
                ST_PDATA:  out_next.next_stage = ST_PACK;
                ST_PACK:   out_next.next_stage = ST_PDONE;
                ST_CANCEL: out_next.next_stage = ST_CDONE;
                default:
                begin
                    out_next.unknown_stage = 1'b1;
                    out_next.advanced      = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign done   = done_reg;
    assign result = out_reg;

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for the USB host-channel halt/complete event update block.
`timescale 1ns / 1ps
module testbench;
    import usbch_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_t  cmd;
    logic done;
    out_t result;

    // Expected records, oldest first.
    out_t expected_records[$];
    int   mismatch_count;
    int   checked_count;
    int   sender_idle_pct;

    usb_channel_halt_update i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Build the error flags that an interrupt word adds.
    function automatic logic [EW-1:0] irq_error_flags(input logic [IW-1:0] irq);
        logic [EW-1:0] flags;
        flags = '0;
        flags[0] = irq[IRQ_AHB];
        flags[1] = irq[IRQ_STALL];
        flags[2] = irq[IRQ_NAK];
        flags[3] = irq[IRQ_NYET];
        flags[10:4] = irq[13:7];
        return flags;
    endfunction

    // Compute the updated channel record for one event.
    function automatic out_t channel_update(input in_t ev);
        out_t           r;
        logic [31:0]    xfer;
        logic [31:0]    want;
        logic [31:0]    dec;
        logic [31:0]    pkts;
        logic [31:0]    mps;
        logic [31:0]    req;
        logic [31:0]    remain;
        logic [31:0]    offset;
        logic [31:0]    final_cnt;
        logic [1:0]     phase;
        logic [3:0]     stg;
        logic           tc;
        logic           nak;
        logic           nyet;
        logic           split_done;
        logic           short_pkt;
        logic           adv;
        logic           fvalid;
        logic           unknown;
        logic           dtog;
        logic           ptog;
        tc = ev.interrupt_bits[IRQ_DONE];
        nak = ev.interrupt_bits[IRQ_NAK];
        nyet = ev.interrupt_bits[IRQ_NYET];
        stg = ev.stage;
        phase = ev.split_state;
        pkts = 32'(ev.packets_left);
        mps = 32'(ev.max_packet);
        req = 32'(ev.request_bytes);
        remain = 32'(ev.remaining_bytes);
        offset = ev.offset_bytes;
        dtog = ev.data_toggle;
        ptog = ev.poll_toggle;
        final_cnt = '0;
        adv = 1'b0;
        fvalid = 1'b0;
        unknown = 1'b0;
        split_done = 1'b0;

        xfer = (remain <= req) ? req - remain : 32'd0;
        want = (mps < req) ? mps : req;

        // Split phase if no nyet or non-poll nak: start to complete; complete ends on nak/done.
        if (phase == SP_START)
        begin
            if (!(nak && stg != ST_PDATA) && !nyet)
                phase = SP_COMPL;
        end
        else if (phase == SP_COMPL)
        begin
            if (!nyet && !(nak && stg != ST_PDATA) && (nak || tc))
            begin
                phase = SP_START;
                split_done = 1'b1;
            end
        end

        short_pkt = (xfer != 0) && (xfer < want);
        if (short_pkt)
            pkts = 32'd0;
        if (split_done && !short_pkt)
            xfer = want;

        if (xfer > 0 || split_done || (phase == SP_NONE && req == 0))
        begin
            if (xfer == 0 && split_done && !short_pkt)
                xfer = mps;
            if (!short_pkt)
            begin
                if (mps == 0)
                    dec = 32'd1;
                else if ((xfer % mps) != 0)
                    dec = 32'd1;
                else
                    dec = xfer / mps;
                pkts = (dec >= pkts) ? 32'd0 : pkts - dec;
            end
        end

        if (ev.interrupt_bits[IRQ_HALT] || tc)
        begin
            if ((stg == ST_SETUP && tc) || (stg == ST_ACK && tc) ||
                (stg == ST_PDATA && (tc || nak)) || stg == ST_CANCEL || pkts == 0)
            begin
                adv = 1'b1;
                if (stg == ST_DATA || stg == ST_ACK || stg == ST_PDATA)
                begin
                    final_cnt = offset + xfer;
                    fvalid = 1'b1;
                end
                offset = 32'd0;
            end
            else
                offset = offset + xfer;
        end

        if (stg == ST_DATA && !adv &&
            ((pkts > 0 && phase == SP_NONE) || (req > 0 && split_done)))
            dtog = ~dtog;
        if (stg == ST_PDATA && tc)
            ptog = ~ptog;

        if (adv)
        begin
            case (stg)
                ST_SETUP:  begin pkts = 32'd0; mps = 32'd0; stg = ST_DATA; end
                ST_DATA:   begin pkts = 32'd0; mps = 32'd0; stg = ST_ACK; end
                ST_ACK:    stg = ST_DONE;
                ST_PDATA:  stg = ST_PACK;
                ST_PACK:   stg = ST_PDONE;
                ST_CANCEL: stg = ST_CDONE;
                default:   begin unknown = 1'b1; adv = 1'b0; end
            endcase
        end

        r.next_stage = stg;
        r.next_split_state = phase;
        r.next_packets_left = pkts[PW-1:0];
        r.next_max_packet = mps[MW-1:0];
        r.next_offset_bytes = offset;
        r.final_bytes = final_cnt;
        r.final_valid = fvalid;
        r.next_data_toggle = dtog;
        r.next_poll_toggle = ptog;
        r.errors_out = ev.errors_in | irq_error_flags(ev.interrupt_bits);
        r.advanced = adv;
        r.unknown_stage = unknown;
        return r;
    endfunction

    // Send one event: wait out random idle cycles, then hold start until taken.
    // Start stays high on return so back-to-back events leave no gap.
    task automatic send_event(input in_t ev);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd <= ev;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_records.push_back(channel_update(ev));
        @(negedge clk);
    endtask

    // Check every result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_records.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                out_t exp_rec;
                exp_rec = expected_records.pop_front();
                checked_count++;
                if (result !== exp_rec)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p actual %p", exp_rec, result);
                end
            end
        end
    end

    // Random event; split phase three and odd stage codes stay rare.
    function automatic in_t random_event();
        in_t ev;
        ev.interrupt_bits = IW'($urandom_range(16383));
        // Bias toward events that halt or complete.
        if ($urandom_range(3) != 0)
            ev.interrupt_bits[$urandom_range(1)] = 1'b1;
        ev.request_bytes = ($urandom_range(3) == 0) ? XW'($urandom_range(524287))
                                                     : XW'($urandom_range(4096));
        case ($urandom_range(3))
            0: ev.remaining_bytes = XW'($urandom_range(524287));
            1: ev.remaining_bytes = ev.request_bytes;
            default: ev.remaining_bytes = (ev.request_bytes > 0)
                       ? XW'($urandom_range(32'(ev.request_bytes))) : '0;
        endcase
        ev.stage = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                             : 4'($urandom_range(8));
        ev.split_state = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
        ev.packets_left = ($urandom_range(3) == 0) ? PW'($urandom_range(1023))
                                                    : PW'($urandom_range(8));
        case ($urandom_range(3))
            0: ev.max_packet = '0;
            1: ev.max_packet = MW'($urandom_range(2047));
            default: ev.max_packet = MW'(8 << $urandom_range(6));
        endcase
        ev.offset_bytes = $urandom();
        ev.data_toggle = 1'($urandom_range(1));
        ev.poll_toggle = 1'($urandom_range(1));
        ev.errors_in = EW'($urandom_range(2047));
        return ev;
    endfunction

    // Drop start and hold until every expected result has come.
    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (expected_records.size() != 0)
            @(negedge clk);
    endtask

    // Extremes, every stage and split phase, and the named corner cases.
    task automatic test_directed();
        in_t ev;
        ev = '0;
        send_event(ev);
        send_event('1);
        for (int s = 0; s < 10; s++)
        begin
            ev = random_event();
            ev.stage = (s == 9) ? 4'd12 : s[3:0];
            ev.interrupt_bits[IRQ_DONE] = 1'b1;
            ev.split_state = 2'(s % 4);
            send_event(ev);
        end
        // Remaining above request saturates the transferred count.
        ev = random_event();
        ev.request_bytes = 19'd10;
        ev.remaining_bytes = 19'd524287;
        send_event(ev);
        // Packet count underflow and zero packet size.
        ev.stage = ST_DATA;
        ev.remaining_bytes = '0;
        ev.request_bytes = 19'd4096;
        ev.max_packet = 11'd8;
        ev.packets_left = 10'd3;
        ev.interrupt_bits = 14'h0002;
        send_event(ev);
        ev.max_packet = '0;
        send_event(ev);
        // No halt and no complete keeps the offset.
        ev.interrupt_bits = 14'h0010;
        ev.offset_bytes = 32'hFFFF_FFFF;
        send_event(ev);
        // Complete split finishing on nak during poll data.
        ev.stage = ST_PDATA;
        ev.split_state = SP_COMPL;
        ev.interrupt_bits = 14'h0012;
        send_event(ev);
        drain_results();
    endtask

    task automatic test_random(input int count, input int idle_pct);
        sender_idle_pct = idle_pct;
        for (int n = 0; n < count; n++)
        begin
            send_event(random_event());
            // Pause once per phase until the pipeline is empty.
            if (n == count / 2)
                drain_results();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        mismatch_count = 0;
        checked_count = 0;
        sender_idle_pct = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(230, 13);
        test_random(230, 56);
        test_random(240, 0);

        drain_results();
        repeat (DIV_STG + 10) @(posedge clk);
        $display("Covered all stage codes, split phases and byte-count corners;");
        $display("%0d results checked.", checked_count);
        if (mismatch_count == 0 && expected_records.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end
endmodule

// ===== usb_channel_halt_update.f =====
hdl/usbch_pkg.sv
hdl/usbch_div.sv
hdl/usb_channel_halt_update.sv
test/testbench.sv
